FILE: rtl/core/rtdv2t_pkg.sv
// shared types and constants for the rtd voltage to temperature converter
`default_nettype none

package rtdv2t_pkg;

  localparam int unsigned W      = 128;
  localparam int unsigned STEP_W = 7;

  typedef enum logic [2:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT,
    ALU_ADD,
    ALU_DIFF
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [STEP_W-1:0] steps;
    logic [W-1:0]      opa;
    logic [W-1:0]      opb;
  } alu_cmd_t;

  typedef struct packed {
    logic done;
    logic flag;
  } alu_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_M1,
    S_M2,
    S_D1,
    S_DR,
    S_M3,
    S_D2,
    S_M4,
    S_DISC,
    S_SQ,
    S_NM,
    S_M5,
    S_D3,
    S_PUT
  } state_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEG_V    = 2'd1;
  localparam logic [1:0] ST_ZERO_R   = 2'd2;
  localparam logic [1:0] ST_NEG_DISC = 2'd3;

  localparam logic [2:0] CFG_BIAS    = 3'd0;
  localparam logic [2:0] CFG_GAIN    = 3'd1;
  localparam logic [2:0] CFG_EXC     = 3'd2;
  localparam logic [2:0] CFG_R0      = 3'd3;
  localparam logic [2:0] CFG_COEFF_A = 3'd4;
  localparam logic [2:0] CFG_COEFF_B = 3'd5;

  localparam logic [22:0] RST_BIAS    = 23'd0;
  localparam logic [24:0] RST_GAIN    = 25'd65536;
  localparam logic [23:0] RST_EXC     = 24'd1000000;
  localparam logic [23:0] RST_R0      = 24'd100000;
  localparam logic [39:0] RST_COEFF_A = 40'd4297221255;
  localparam logic [40:0] RST_COEFF_B = -41'sd41613260604;

  localparam logic [19:0] UV_SCALE   = 20'd1000000;
  localparam logic [24:0] TEMP_SCALE = 25'd32768000;

  localparam logic [STEP_W-1:0] STEPS_UV   = 7'd20;
  localparam logic [STEP_W-1:0] STEPS_GE   = 7'd24;
  localparam logic [STEP_W-1:0] STEPS_R    = 7'd59;
  localparam logic [STEP_W-1:0] STEPS_DIFF = 7'd2;
  localparam logic [STEP_W-1:0] STEPS_BDR  = 7'd41;
  localparam logic [STEP_W-1:0] STEPS_TERM = 7'd126;
  localparam logic [STEP_W-1:0] STEPS_AA   = 7'd40;
  localparam logic [STEP_W-1:0] STEPS_ADD  = 7'd1;
  localparam logic [STEP_W-1:0] STEPS_SQRT = 7'd64;
  localparam logic [STEP_W-1:0] STEPS_NT   = 7'd25;
  localparam logic [STEP_W-1:0] STEPS_Q    = 7'd89;

  localparam logic [20:0] TEMP_MAX     = 21'd1000000;
  localparam logic [20:0] TEMP_MIN_MAG = 21'd273150;
  localparam logic [20:0] TEMP_MIN     = -21'sd273150;

endpackage

`default_nettype wire

FILE: rtl/core/rtdv2t_alu.sv
// shared bit-serial unit: multiply, divide, square root, add and absolute difference
`default_nettype none

module rtdv2t_alu (
  input  logic                  clk,
  input  logic                  rst,
  input  rtdv2t_pkg::alu_cmd_t  cmd,
  output rtdv2t_pkg::alu_stat_t stat,
  output logic [127:0]          result
);

  logic                          busy;
  logic                          done;
  logic                          flag;
  rtdv2t_pkg::alu_op_t           op_q;
  logic [rtdv2t_pkg::STEP_W-1:0] cnt;
  logic [127:0]                  a_reg;
  logic [127:0]                  b_reg;
  logic [66:0]                   r_reg;
  logic [63:0]                   d_reg;

  logic [64:0]  shl_div;
  logic [66:0]  shl_sqrt;
  logic [127:0] lhs;
  logic [127:0] rhs;
  logic         sub;
  logic [128:0] sum;
  logic         ge;
  logic         last;

  always_comb begin
    shl_div  = {r_reg[63:0], a_reg[127]};
    shl_sqrt = {r_reg[64:0], a_reg[127:126]};
    lhs      = a_reg;
    rhs      = b_reg;
    sub      = 1'b0;
    unique case (op_q)
      rtdv2t_pkg::ALU_MUL: begin
        rhs = r_reg[0] ? b_reg : '0;
      end
      rtdv2t_pkg::ALU_DIV: begin
        lhs = {63'd0, shl_div};
        rhs = {64'd0, d_reg};
        sub = 1'b1;
      end
      rtdv2t_pkg::ALU_SQRT: begin
        lhs = {61'd0, shl_sqrt};
        rhs = {62'd0, b_reg[63:0], 2'b01};
        sub = 1'b1;
      end
      rtdv2t_pkg::ALU_ADD: begin
        sub = 1'b0;
      end
      rtdv2t_pkg::ALU_DIFF: begin
        sub = 1'b1;
      end
      default: begin
        sub = 1'b0;
      end
    endcase
    sum  = {1'b0, lhs} + {1'b0, (sub ? ~rhs : rhs)} + {128'd0, sub};
    ge   = sum[128];
    last = (cnt == 7'd1) || ((op_q == rtdv2t_pkg::ALU_DIFF) && ge);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q  <= cmd.op;
      cnt   <= cmd.steps;
      flag  <= 1'b1;
      a_reg <= (cmd.op == rtdv2t_pkg::ALU_MUL) ? '0 : cmd.opa;
      b_reg <= (cmd.op == rtdv2t_pkg::ALU_MUL)  ? cmd.opa :
               (cmd.op == rtdv2t_pkg::ALU_SQRT) ? '0 : cmd.opb;
      r_reg <= (cmd.op == rtdv2t_pkg::ALU_MUL) ? cmd.opb[66:0] : '0;
      d_reg <= cmd.opb[63:0];
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      case (op_q)
        rtdv2t_pkg::ALU_MUL: begin
          a_reg <= sum[127:0];
          b_reg <= {b_reg[126:0], 1'b0};
          r_reg <= {1'b0, r_reg[66:1]};
        end
        rtdv2t_pkg::ALU_DIV: begin
          r_reg <= ge ? {2'b00, sum[64:0]} : {2'b00, shl_div};
          a_reg <= {a_reg[126:0], ge};
        end
        rtdv2t_pkg::ALU_SQRT: begin
          r_reg <= ge ? sum[66:0] : shl_sqrt;
          b_reg <= {b_reg[126:0], ge};
          a_reg <= {a_reg[125:0], 2'b00};
        end
        rtdv2t_pkg::ALU_ADD: begin
          a_reg <= sum[127:0];
        end
        rtdv2t_pkg::ALU_DIFF: begin
          if (ge) begin
            a_reg <= sum[127:0];
          end else begin
            // swap and subtract the other way on the next step
            a_reg <= b_reg;
            b_reg <= a_reg;
            flag  <= 1'b0;
          end
        end
        default: begin
          a_reg <= a_reg;
        end
      endcase
    end
  end

  assign stat.done = done;
  assign stat.flag = flag;
  assign result    = (op_q == rtdv2t_pkg::ALU_SQRT) ? b_reg : a_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rtd_voltage_to_temperature.sv
// Converts one front-end voltage in microvolts to an RTD temperature in millidegrees C.
// The voltage minus the bias is scaled to a sensor resistance, the quadratic
// R = R0 (1 + A T + B T^2) is solved for T with an exact integer square root, and the
// result is saturated to -273150 .. 1000000 with a status code. The multiplies, divides,
// square root and differences run through one shared bit-serial add/subtract unit that
// works every multiply, divide and square root one bit per cycle. An item that ends early
// gives a nonzero status: negative voltage, zero resistance or negative discriminant.
// The block takes one item at a time and is ready again as soon as the result is
// registered; a finished result waits in the output register while the next item is taken.
// Configuration writes are taken every cycle and must only be made while the block is idle.
`default_nettype none

module rtd_voltage_to_temperature (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [40:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [22:0] voltage_uv,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [20:0] temp_mdeg,
  output logic [1:0]         status
);

  // configuration registers
  logic signed [22:0] bias_uv;
  logic [24:0]        gain_q16;
  logic [23:0]        excitation_na;
  logic [23:0]        r0_mohm;
  logic [39:0]        coeff_a_q40;
  logic signed [40:0] coeff_b_q56;

  logic [24:0] gain_eff;
  logic [23:0] exc_eff;
  logic [23:0] r0_eff;
  logic [40:0] b_eff;
  logic        bneg;
  logic [40:0] bmag;
  logic        term_pos;

  rtdv2t_pkg::state_t    state;
  rtdv2t_pkg::state_t    state_next;
  rtdv2t_pkg::alu_cmd_t  cmd;
  rtdv2t_pkg::alu_stat_t alu_stat;
  logic [127:0]          alu_res;

  logic [23:0]  d;
  logic [42:0]  prod1;
  logic [42:0]  prod1_next;
  logic         r0ger;
  logic         r0ger_next;
  logic [125:0] term;
  logic [125:0] term_next;
  logic         neg;
  logic         neg_next;
  logic [20:0]  pend_temp;
  logic [20:0]  pend_temp_next;
  logic [1:0]   pend_status;
  logic [1:0]   pend_status_next;
  logic [88:0]  q;
  logic         put_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == rtdv2t_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_uv       <= rtdv2t_pkg::RST_BIAS;
      gain_q16      <= rtdv2t_pkg::RST_GAIN;
      excitation_na <= rtdv2t_pkg::RST_EXC;
      r0_mohm       <= rtdv2t_pkg::RST_R0;
      coeff_a_q40   <= rtdv2t_pkg::RST_COEFF_A;
      coeff_b_q56   <= rtdv2t_pkg::RST_COEFF_B;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtdv2t_pkg::CFG_BIAS:    bias_uv       <= cfg_data[22:0];
        rtdv2t_pkg::CFG_GAIN:    gain_q16      <= cfg_data[24:0];
        rtdv2t_pkg::CFG_EXC:     excitation_na <= cfg_data[23:0];
        rtdv2t_pkg::CFG_R0:      r0_mohm       <= cfg_data[23:0];
        rtdv2t_pkg::CFG_COEFF_A: coeff_a_q40   <= cfg_data[39:0];
        rtdv2t_pkg::CFG_COEFF_B: coeff_b_q56   <= cfg_data[40:0];
        default: begin
          bias_uv <= bias_uv;
        end
      endcase
    end
  end

  // a zero gain, excitation or r0 is used as one, a zero b as minus one
  always_comb begin
    gain_eff = (gain_q16 == '0) ? 25'd1 : gain_q16;
    exc_eff  = (excitation_na == '0) ? 24'd1 : excitation_na;
    r0_eff   = (r0_mohm == '0) ? 24'd1 : r0_mohm;
    b_eff    = (coeff_b_q56 == '0) ? '1 : coeff_b_q56;
    bneg     = b_eff[40];
    bmag     = bneg ? (~b_eff + 41'd1) : b_eff;
    term_pos = (bneg == r0ger);
    q        = alu_res[88:0];
    put_ok   = !out_valid || out_ready;
  end

  rtdv2t_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (alu_stat),
    .result (alu_res)
  );

  always_comb begin
    state_next       = state;
    prod1_next       = prod1;
    r0ger_next       = r0ger;
    term_next        = term;
    neg_next         = neg;
    pend_temp_next   = pend_temp;
    pend_status_next = pend_status;
    cmd.start        = 1'b0;
    cmd.op           = rtdv2t_pkg::ALU_MUL;
    cmd.steps        = '0;
    cmd.opa          = '0;
    cmd.opb          = '0;
    unique case (state)
      rtdv2t_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = rtdv2t_pkg::S_CHK;
        end
      end
      rtdv2t_pkg::S_CHK: begin
        if (d[23]) begin
          pend_temp_next   = '0;
          pend_status_next = rtdv2t_pkg::ST_NEG_V;
          state_next       = rtdv2t_pkg::S_PUT;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = rtdv2t_pkg::ALU_MUL;
          cmd.steps  = rtdv2t_pkg::STEPS_UV;
          cmd.opa    = {105'd0, d[22:0]};
          cmd.opb    = {108'd0, rtdv2t_pkg::UV_SCALE};
          state_next = rtdv2t_pkg::S_M1;
        end
      end
      rtdv2t_pkg::S_M1: begin
        if (alu_stat.done) begin
          prod1_next = alu_res[42:0];
          cmd.start  = 1'b1;
          cmd.op     = rtdv2t_pkg::ALU_MUL;
          cmd.steps  = rtdv2t_pkg::STEPS_GE;
          cmd.opa    = {103'd0, gain_eff};
          cmd.opb    = {104'd0, exc_eff};
          state_next = rtdv2t_pkg::S_M2;
        end
      end
      rtdv2t_pkg::S_M2: begin
        if (alu_stat.done) begin
          // numerator is prod1 times 2^16, aligned to the top bit
          cmd.start  = 1'b1;
          cmd.op     = rtdv2t_pkg::ALU_DIV;
          cmd.steps  = rtdv2t_pkg::STEPS_R;
          cmd.opa    = {prod1, 85'd0};
          cmd.opb    = {79'd0, alu_res[48:0]};
          state_next = rtdv2t_pkg::S_D1;
        end
      end
      rtdv2t_pkg::S_D1: begin
        if (alu_stat.done) begin
          if (alu_res[58:0] == '0) begin
            pend_temp_next   = '0;
            pend_status_next = rtdv2t_pkg::ST_ZERO_R;
            state_next       = rtdv2t_pkg::S_PUT;
          end else begin
            cmd.start  = 1'b1;
            cmd.op     = rtdv2t_pkg::ALU_DIFF;
            cmd.steps  = rtdv2t_pkg::STEPS_DIFF;
            cmd.opa    = {104'd0, r0_eff};
            cmd.opb    = {69'd0, alu_res[58:0]};
            state_next = rtdv2t_pkg::S_DR;
          end
        end
      end
      rtdv2t_pkg::S_DR: begin
        if (alu_stat.done) begin
          r0ger_next = alu_stat.flag;
          cmd.start  = 1'b1;
          cmd.op     = rtdv2t_pkg::ALU_MUL;
          cmd.steps  = rtdv2t_pkg::STEPS_BDR;
          cmd.opa    = {69'd0, alu_res[58:0]};
          cmd.opb    = {87'd0, bmag};
          state_next = rtdv2t_pkg::S_M3;
        end
      end
      rtdv2t_pkg::S_M3: begin
        if (alu_stat.done) begin
          // times 2^26, aligned to the top bit
          cmd.start  = 1'b1;
          cmd.op     = rtdv2t_pkg::ALU_DIV;
          cmd.steps  = rtdv2t_pkg::STEPS_TERM;
          cmd.opa    = {alu_res[99:0], 28'd0};
          cmd.opb    = {104'd0, r0_eff};
          state_next = rtdv2t_pkg::S_D2;
        end
      end
      rtdv2t_pkg::S_D2: begin
        if (alu_stat.done) begin
          term_next  = alu_res[125:0];
          cmd.start  = 1'b1;
          cmd.op     = rtdv2t_pkg::ALU_MUL;
          cmd.steps  = rtdv2t_pkg::STEPS_AA;
          cmd.opa    = {88'd0, coeff_a_q40};
          cmd.opb    = {88'd0, coeff_a_q40};
          state_next = rtdv2t_pkg::S_M4;
        end
      end
      rtdv2t_pkg::S_M4: begin
        if (alu_stat.done) begin
          cmd.start  = 1'b1;
          cmd.op     = term_pos ? rtdv2t_pkg::ALU_ADD : rtdv2t_pkg::ALU_DIFF;
          cmd.steps  = term_pos ? rtdv2t_pkg::STEPS_ADD : rtdv2t_pkg::STEPS_DIFF;
          cmd.opa    = alu_res;
          cmd.opb    = {2'd0, term};
          state_next = rtdv2t_pkg::S_DISC;
        end
      end
      rtdv2t_pkg::S_DISC: begin
        if (alu_stat.done) begin
          if (!term_pos && !alu_stat.flag) begin
            pend_temp_next   = '0;
            pend_status_next = rtdv2t_pkg::ST_NEG_DISC;
            state_next       = rtdv2t_pkg::S_PUT;
          end else begin
            cmd.start  = 1'b1;
            cmd.op     = rtdv2t_pkg::ALU_SQRT;
            cmd.steps  = rtdv2t_pkg::STEPS_SQRT;
            cmd.opa    = alu_res;
            state_next = rtdv2t_pkg::S_SQ;
          end
        end
      end
      rtdv2t_pkg::S_SQ: begin
        if (alu_stat.done) begin
          cmd.start  = 1'b1;
          cmd.op     = rtdv2t_pkg::ALU_DIFF;
          cmd.steps  = rtdv2t_pkg::STEPS_DIFF;
          cmd.opa    = {64'd0, alu_res[63:0]};
          cmd.opb    = {88'd0, coeff_a_q40};
          state_next = rtdv2t_pkg::S_NM;
        end
      end
      rtdv2t_pkg::S_NM: begin
        if (alu_stat.done) begin
          // negative when s >= a and b > 0 disagree, never for a zero magnitude
          neg_next   = (alu_stat.flag == bneg) && (alu_res[63:0] != '0);
          cmd.start  = 1'b1;
          cmd.op     = rtdv2t_pkg::ALU_MUL;
          cmd.steps  = rtdv2t_pkg::STEPS_NT;
          cmd.opa    = {64'd0, alu_res[63:0]};
          cmd.opb    = {103'd0, rtdv2t_pkg::TEMP_SCALE};
          state_next = rtdv2t_pkg::S_M5;
        end
      end
      rtdv2t_pkg::S_M5: begin
        if (alu_stat.done) begin
          cmd.start  = 1'b1;
          cmd.op     = rtdv2t_pkg::ALU_DIV;
          cmd.steps  = rtdv2t_pkg::STEPS_Q;
          cmd.opa    = {alu_res[88:0], 39'd0};
          cmd.opb    = {87'd0, bmag};
          state_next = rtdv2t_pkg::S_D3;
        end
      end
      rtdv2t_pkg::S_D3: begin
        if (alu_stat.done) begin
          pend_status_next = rtdv2t_pkg::ST_OK;
          if (neg) begin
            if (q > {68'd0, rtdv2t_pkg::TEMP_MIN_MAG}) begin
              pend_temp_next = rtdv2t_pkg::TEMP_MIN;
            end else begin
              pend_temp_next = 21'd0 - q[20:0];
            end
          end else begin
            if (q > {68'd0, rtdv2t_pkg::TEMP_MAX}) begin
              pend_temp_next = rtdv2t_pkg::TEMP_MAX;
            end else begin
              pend_temp_next = q[20:0];
            end
          end
          state_next = rtdv2t_pkg::S_PUT;
        end
      end
      rtdv2t_pkg::S_PUT: begin
        if (put_ok) begin
          state_next = rtdv2t_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rtdv2t_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtdv2t_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d <= {voltage_uv[22], voltage_uv} - {bias_uv[22], bias_uv};
    end
    prod1       <= prod1_next;
    r0ger       <= r0ger_next;
    term        <= term_next;
    neg         <= neg_next;
    pend_temp   <= pend_temp_next;
    pend_status <= pend_status_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == rtdv2t_pkg::S_PUT) && put_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == rtdv2t_pkg::S_PUT) && put_ok) begin
      temp_mdeg <= pend_temp;
      status    <= pend_status;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rtdv2t_checker.sv
// port-level checks for the rtd voltage to temperature converter
`default_nettype none

module rtdv2t_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [20:0] temp_mdeg,
  input logic [1:0]         status
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(temp_mdeg) && $stable(status)))
    else $error("stalled result changed");

  a_err_zero_temp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != rtdv2t_pkg::ST_OK)) |-> (temp_mdeg == 21'sd0))
    else $error("nonzero temperature with error status");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == rtdv2t_pkg::ST_OK)) |->
      ((temp_mdeg >= $signed(rtdv2t_pkg::TEMP_MIN)) &&
       (temp_mdeg <= $signed(rtdv2t_pkg::TEMP_MAX))))
    else $error("temperature outside saturation range");

endmodule

bind rtd_voltage_to_temperature rtdv2t_checker u_rtdv2t_checker (.*);

`default_nettype wire
